FILE: rtl/bandlimited_saw_oscillator_assert.svh
// Assertion macros for the saw oscillator checks.
// They expect clk and rst_n in scope.
`ifndef BANDLIMITED_SAW_OSCILLATOR_ASSERT_SVH
`define BANDLIMITED_SAW_OSCILLATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define BSO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bso: same-cycle check failed");

// next-cycle implication, off during reset
`define BSO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bso: next-cycle check failed");

// next-cycle implication that also runs through reset
`define BSO_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bso: reset check failed");

`endif

FILE: rtl/bso_pkg.sv
package bso_pkg;

  localparam int TABLE_SIZE_DEF = 1002;

  localparam int FREQ_W     = 33;
  localparam int FRAC_W     = 12;
  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 18;
  localparam int ROM_W      = 16;
  localparam int STEP_W     = 24;
  localparam int BAND_W     = 20;
  localparam int MAG_W      = 20;
  localparam int D_W        = MAG_W + 7;          // 100 * mag
  localparam int KB_W       = BAND_W + 6;         // 33 * band
  localparam int A_W        = PHASE_W + KB_W - 1; // |p| * 33 * band < 2^57
  localparam int LO_W       = 29;                 // low split of a for the 2H product
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HZ     = 2'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd97391;
  localparam logic [BAND_W-1:0] BAND_RESET = 20'd22000;
  localparam logic [MAG_W-1:0]  MAG_MAX    = 20'd999999;

  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_SET_PHASE = 1'b1;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  typedef struct packed {
    logic                     op;
    logic signed [FREQ_W-1:0] freq;
    logic [MAG_W-1:0]         mag;
    logic [PHASE_W-1:0]       phase_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic                       wr;
    logic signed [SAMPLE_W-1:0] sample;
  } res_t;

  // cos(x) in Q30 for 0 <= x <= pi/2, Horner form of the degree-12 series
  function automatic longint cos_poly(input longint x);
    longint x2;
    longint term;
    x2   = (x * x) >>> 30;
    term = Q30_ONE;
    term = Q30_ONE - ((x2 * term) >>> 30) / 132;
    term = Q30_ONE - ((x2 * term) >>> 30) / 90;
    term = Q30_ONE - ((x2 * term) >>> 30) / 56;
    term = Q30_ONE - ((x2 * term) >>> 30) / 30;
    term = Q30_ONE - ((x2 * term) >>> 30) / 12;
    term = Q30_ONE - ((x2 * term) >>> 30) / 2;
    return term;
  endfunction

endpackage

FILE: rtl/bso_front.sv
module bso_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic                              in_req_type,
  input  logic signed [bso_pkg::FREQ_W-1:0] in_freq,
  input  logic [bso_pkg::PHASE_W-1:0]       in_phase_value,
  output bso_pkg::q_head_t                  head_o,
  input  logic                              pop_i
);

  localparam int DEPTH = bso_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MRW   = bso_pkg::FREQ_W + 1 - bso_pkg::FRAC_W;

  bso_pkg::item_t slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  logic                            push_ok;
  logic                            pop_ok;
  logic signed [bso_pkg::FREQ_W:0] freq_x;
  logic [bso_pkg::FREQ_W:0]        freq_abs;
  logic [MRW-1:0]                  mag_raw;
  logic [bso_pkg::MAG_W-1:0]       mag;
  bso_pkg::item_t                  item_in;

  assign full    = (cnt_r == CW'(DEPTH));
  assign push_ok = push && !full;
  assign pop_ok  = pop_i && (cnt_r != '0);

  // classify: decode the request and clamp |freq| to whole Hz in 1..999999
  always_comb begin
    freq_x   = {in_freq[bso_pkg::FREQ_W-1], in_freq};
    freq_abs = freq_x[bso_pkg::FREQ_W] ? -freq_x : freq_x;
    mag_raw  = freq_abs[bso_pkg::FREQ_W:bso_pkg::FRAC_W];
    if (mag_raw > MRW'(bso_pkg::MAG_MAX)) begin
      mag = bso_pkg::MAG_MAX;
    end else if (mag_raw == '0) begin
      mag = bso_pkg::MAG_W'(1);
    end else begin
      mag = mag_raw[bso_pkg::MAG_W-1:0];
    end
    item_in.op          = in_req_type ? bso_pkg::OP_SET_PHASE : bso_pkg::OP_SAMPLE;
    item_in.freq        = in_freq;
    item_in.mag         = mag;
    item_in.phase_value = in_phase_value;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign head_o.valid = (cnt_r != '0);
  assign head_o.item  = slot_r[rd_ptr_r];

endmodule

FILE: rtl/bso_back.sv
module bso_back #(
  parameter int TABLE_SIZE = bso_pkg::TABLE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bso_pkg::q_head_t           head_i,
  output logic                       pop_o,
  input  logic [bso_pkg::STEP_W-1:0] step_i,
  input  logic [bso_pkg::BAND_W-1:0] band_i,
  input  logic                       res_free_i,
  output bso_pkg::res_t              res_o
);

  localparam int H      = (TABLE_SIZE - 2) / 2;
  localparam longint M2 = 2 * H;
  localparam longint DN = 64'sd1638400000;
  localparam int QW     = $clog2(H);           // quotient bits below H
  localparam int QBW    = QW + 1;              // also holds H itself
  localparam int HBW    = $clog2(2 * H + 1);
  localparam int IW     = $clog2(TABLE_SIZE);
  localparam int RW     = bso_pkg::A_W + HBW;
  localparam int HI_W   = bso_pkg::A_W - bso_pkg::LO_W;
  localparam int CNT_W  = $clog2(QW + 1);
  localparam int PW     = bso_pkg::PHASE_W;
  localparam int PRW    = bso_pkg::FREQ_W + bso_pkg::STEP_W + 1;

  localparam logic [HBW-1:0] TWO_H  = HBW'(2 * H);
  localparam logic [QBW-1:0] H_Q    = QBW'(H);
  localparam logic [IW-1:0]  H_P1   = IW'(H + 1);
  localparam logic [PW-1:0]  HALF_P = {1'b1, {(PW - 1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_IDX  = 4'd6;
  localparam logic [3:0] S_ROM  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // correction ROM: -cos j + cos 3j / 3 - cos 5j / 5, scaled and rounded to signed 16-bit
  logic signed [bso_pkg::ROM_W-1:0] rom_c [TABLE_SIZE];

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    localparam longint K1  = (gi == 0) ? 1 : gi - 1;
    localparam longint K3  = 3 * K1;
    localparam longint K5  = 5 * K1;
    localparam longint T1A = K1 % (2 * M2);
    localparam longint T1B = (T1A > M2) ? 2 * M2 - T1A : T1A;
    localparam bit     N1  = (2 * T1B > M2);
    localparam longint T1C = N1 ? M2 - T1B : T1B;
    localparam longint C1P = bso_pkg::cos_poly(bso_pkg::PI_Q30 * T1C / M2);
    localparam longint C1  = N1 ? -C1P : C1P;
    localparam longint T3A = K3 % (2 * M2);
    localparam longint T3B = (T3A > M2) ? 2 * M2 - T3A : T3A;
    localparam bit     N3  = (2 * T3B > M2);
    localparam longint T3C = N3 ? M2 - T3B : T3B;
    localparam longint C3P = bso_pkg::cos_poly(bso_pkg::PI_Q30 * T3C / M2);
    localparam longint C3  = N3 ? -C3P : C3P;
    localparam longint T5A = K5 % (2 * M2);
    localparam longint T5B = (T5A > M2) ? 2 * M2 - T5A : T5A;
    localparam bit     N5  = (2 * T5B > M2);
    localparam longint T5C = N5 ? M2 - T5B : T5B;
    localparam longint C5P = bso_pkg::cos_poly(bso_pkg::PI_Q30 * T5C / M2);
    localparam longint C5  = N5 ? -C5P : C5P;
    localparam longint SUM = -C1 + (C3 * 333333) / 1000000 - C5 / 5;
    localparam longint V   = SUM * 57692;
    localparam longint R   = (V >= 0) ? (V + DN / 2) / DN : -((-V + DN / 2) / DN);
    localparam longint RS  = (R > 32767) ? 32767 : ((R < -32768) ? -32768 : R);
    localparam logic signed [bso_pkg::ROM_W-1:0] ENT = bso_pkg::ROM_W'(RS);
    assign rom_c[gi] = ENT;
  end

  logic [3:0]                       state_r;
  logic [3:0]                       state_nxt;
  logic [PW-1:0]                    phase_r;
  logic signed [bso_pkg::FREQ_W-1:0] freq_r;
  logic [bso_pkg::MAG_W-1:0]        mag_r;
  logic [PW-1:0]                    absp_r;
  logic                             psign_r;
  logic [bso_pkg::KB_W-1:0]         kb_r;
  logic [bso_pkg::A_W-1:0]          a_r;
  logic [bso_pkg::D_W-1:0]          d_r;
  logic                             sat_r;
  logic [bso_pkg::LO_W+HBW-1:0]     lo_r;
  logic [HI_W+HBW-1:0]              hi_r;
  logic [RW-1:0]                    rem_r;
  logic [RW-1:0]                    dsh_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [QBW-1:0]                   q_r;
  logic [PW-1:0]                    prod_r;
  logic [IW-1:0]                    idx_r;
  logic signed [bso_pkg::ROM_W-1:0] rom_q_r;

  logic [PW+bso_pkg::KB_W-1:0] a_full;
  logic signed [PRW-1:0]       prod_full;
  logic [RW:0]                 diff;
  logic                        exact;
  logic [IW-1:0]               q_ext;
  logic [IW-1:0]               idx_nxt;

  always_comb begin
    state_nxt = state_r;
    pop_o     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.op == bso_pkg::OP_SAMPLE) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_SUM;
      S_SUM:  state_nxt = sat_r ? S_IDX : S_DIV;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_IDX;
        end
      end
      S_IDX:  state_nxt = S_ROM;
      S_ROM:  state_nxt = S_OUT;
      S_OUT: begin
        if (res_free_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    a_full    = absp_r * kb_r;
    prod_full = freq_r * $signed({1'b0, step_i});
    diff      = {1'b0, rem_r} - {1'b0, dsh_r};
    exact     = (rem_r == '0);
    q_ext     = IW'(q_r);
    if (psign_r) begin
      idx_nxt = H_P1 + q_ext;
    end else begin
      idx_nxt = H_P1 - q_ext - IW'(!exact);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && head_i.valid && head_i.item.op == bso_pkg::OP_SET_PHASE) begin
        phase_r <= head_i.item.phase_value;
      end else if (state_r == S_OUT && res_free_i) begin
        phase_r <= phase_r + prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        freq_r <= head_i.item.freq;
        mag_r  <= head_i.item.mag;
      end
      S_PREP: begin
        // p = phase - 2^31; phase bit 31 set means p >= 0
        psign_r <= phase_r[PW-1];
        absp_r  <= phase_r[PW-1] ? {1'b0, phase_r[PW-2:0]} : HALF_P - {1'b0, phase_r[PW-2:0]};
        kb_r    <= {band_i, 5'b0} + bso_pkg::KB_W'(band_i);
      end
      S_MUL: begin
        a_r <= a_full[bso_pkg::A_W-1:0];
        d_r <= (bso_pkg::D_W'(mag_r) << 6) + (bso_pkg::D_W'(mag_r) << 5)
             + (bso_pkg::D_W'(mag_r) << 2);
      end
      S_CMP: begin
        // |f| >= 0.5 when 2a >= d * 2^32
        sat_r <= ({1'b0, a_r} >= {d_r, {(PW - 1){1'b0}}});
        lo_r  <= a_r[bso_pkg::LO_W-1:0] * TWO_H;
        hi_r  <= a_r[bso_pkg::A_W-1:bso_pkg::LO_W] * TWO_H;
      end
      S_SUM: begin
        if (sat_r) begin
          rem_r <= '0;
          q_r   <= H_Q;
        end else begin
          rem_r <= {hi_r, {bso_pkg::LO_W{1'b0}}}
                 + {{(RW - bso_pkg::LO_W - HBW){1'b0}}, lo_r};
          q_r   <= '0;
        end
        dsh_r  <= RW'({d_r, {PW{1'b0}}}) << (QW - 1);
        cnt_r  <= CNT_W'(QW - 1);
        prod_r <= prod_full[bso_pkg::FRAC_W+PW-1:bso_pkg::FRAC_W];
      end
      S_DIV: begin
        if (!diff[RW]) begin
          rem_r <= diff[RW-1:0];
        end
        q_r   <= {q_r[QW-1:0], !diff[RW]};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      S_IDX: begin
        idx_r <= idx_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q_r <= rom_c[idx_r];
  end

  assign res_o.wr     = (state_r == S_OUT) && res_free_i;
  assign res_o.sample = {2'b00, phase_r[PW-1:PW-bso_pkg::ROM_W]}
                      - {{(bso_pkg::SAMPLE_W - bso_pkg::ROM_W){rom_q_r[bso_pkg::ROM_W-1]}},
                         rom_q_r};

endmodule

FILE: rtl/bandlimited_saw_oscillator.sv
// channel | handshake                  | payload
// --------+----------------------------+-----------------------------------------
// input   | push / full                | in_req_type, in_freq, in_phase_value
// result  | empty / pop                | out_sample_out
// config  | cfg_valid / cfg_ready      | cfg_index, cfg_wdata
//
// An audio item passes through the back-end states prep, mul, cmp, sum, div, idx, rom and out;
// div is skipped when the correction saturates. The restoring divider yields one quotient bit a cycle.
// A set-phase item is taken in the idle state. A two-entry input queue keeps push open meanwhile.
// Synchronous active-low reset: phase 0, step and band to their defaults, queues empty.
// A result held in the output register does not stop the back end until the next result.
module bandlimited_saw_oscillator #(
  parameter int TABLE_SIZE = bso_pkg::TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_req_type,
  input  logic signed [bso_pkg::FREQ_W-1:0]   in_freq,
  input  logic [bso_pkg::PHASE_W-1:0]         in_phase_value,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bso_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bso_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bso_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [bso_pkg::STEP_W-1:0]         step_r;
  logic [bso_pkg::BAND_W-1:0]         band_r;
  logic                               out_valid_r;
  logic signed [bso_pkg::SAMPLE_W-1:0] out_sample_r;

  bso_pkg::q_head_t head;
  logic             head_pop;
  bso_pkg::res_t    res;
  logic             res_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bso_pkg::STEP_RESET;
      band_r <= bso_pkg::BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bso_pkg::REG_STEP_PER_HZ: step_r <= cfg_wdata[bso_pkg::STEP_W-1:0];
        bso_pkg::REG_BAND_HZ:     band_r <= cfg_wdata[bso_pkg::BAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bso_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_freq        (in_freq),
    .in_phase_value (in_phase_value),
    .head_o         (head),
    .pop_i          (head_pop)
  );

  bso_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_i     (head),
    .pop_o      (head_pop),
    .step_i     (step_r),
    .band_i     (band_r),
    .res_free_i (res_free),
    .res_o      (res)
  );

  // output register; a new result may replace one that transfers this cycle
  assign res_free = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.wr) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.wr) begin
      out_sample_r <= res.sample;
    end
  end

  assign empty          = !out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

FILE: rtl/bso_checker.sv
`include "bandlimited_saw_oscillator_assert.svh"

module bso_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                push,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic signed [bso_pkg::SAMPLE_W-1:0] out_sample_out
);

  `BSO_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(out_sample_out))
  // the input queue only fills on a push, the result slot only drains on a pop
  `BSO_ASSERT_IMP(a_full_on_push, $rose(full) && $past(rst_n), $past(push))
  `BSO_ASSERT_IMP(a_empty_on_pop, $rose(empty) && $past(rst_n), $past(pop))
  `BSO_ASSERT_RST(a_reset_clear, !rst_n, empty && !full)

endmodule

bind bandlimited_saw_oscillator bso_checker u_bso_checker (.*);
